FILE: rtl/palette_nearest_color_16_macros.svh
// Assertion macros shared by the nearest palette color RTL.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef PALETTE_NEAREST_COLOR_16_MACROS_SVH
`define PALETTE_NEAREST_COLOR_16_MACROS_SVH

`define PNC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define PNC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pnc_pkg.sv
// Types, constants and helper functions of the nearest palette color block.
// No dependencies; imported by every RTL file but the assertion macro header.
`default_nettype none

package pnc_pkg;

   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned SQ_W    = 2 * CHAN_W;
   localparam int unsigned DIST_W  = SQ_W + 2;
   localparam int unsigned INDEX_W = 4;

   localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(3 * 255 * 255);
   localparam logic [DIST_W-1:0] DIST_PAD = '1;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_PIXEL = 1'b1
   } pnc_mode_type;

   typedef logic [CHAN_W-1:0] pnc_chan_type;

   typedef struct packed {
      pnc_chan_type red;
      pnc_chan_type green;
      pnc_chan_type blue;
   } pnc_rgb_type;

   typedef struct packed {
      logic [SQ_W-1:0] red;
      logic [SQ_W-1:0] green;
      logic [SQ_W-1:0] blue;
   } pnc_sq_type;

   typedef struct packed {
      logic valid;
      logic last;
   } pnc_tag_type;

   function automatic pnc_chan_type abs_diff(input pnc_chan_type a, input pnc_chan_type b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pnc_req_if.sv
// Request channel: valid/ready handshake carrying a load or pixel transaction.
// Depends on pnc_pkg.
`default_nettype none

interface pnc_req_if import pnc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [INDEX_W-1:0]   entry_index;
   logic [CHAN_W-1:0]    red;
   logic [CHAN_W-1:0]    green;
   logic [CHAN_W-1:0]    blue;
   logic                 last_pixel;

   modport source (output valid, mode, entry_index, red, green, blue, last_pixel,
                   input ready);
   modport sink (input valid, mode, entry_index, red, green, blue, last_pixel,
                 output ready);
endinterface

`default_nettype wire

FILE: rtl/pnc_rsp_if.sv
// Response channel: valid/ready handshake carrying the nearest color index.
// Depends on pnc_pkg.
`default_nettype none

interface pnc_rsp_if import pnc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [INDEX_W-1:0]   color_index;
   logic                 frame_end;

   modport source (output valid, color_index, frame_end, input ready);
   modport sink (input valid, color_index, frame_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/pnc_diff.sv
// Palette register file and first pipeline stage (per-entry channel differences).
// Depends on pnc_pkg and the assertion macro header.
`default_nettype none
`include "palette_nearest_color_16_macros.svh"

module pnc_diff import pnc_pkg::*; #(
   parameter int unsigned ENTRIES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               load_write,
   input  wire logic [INDEX_W-1:0] entry_index,
   input  wire pnc_rgb_type        color,
   input  wire pnc_tag_type        tag_s0,
   output pnc_rgb_type             diff [ENTRIES],
   output pnc_tag_type             tag
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam int unsigned SEL_W = IDX_W + INDEX_W;

   pnc_rgb_type palette_ff [ENTRIES];
   pnc_rgb_type diff_in [ENTRIES];
   pnc_rgb_type diff_ff [ENTRIES];
   logic [ENTRIES-1:0] hit;
   pnc_tag_type tag_ff;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_lane
      localparam logic [SEL_W-1:0] LANE = SEL_W'(i);

      assign hit[i] = load_write && ({{IDX_W{1'b0}}, entry_index} == LANE);

      always_ff @(posedge clock) begin
         if (reset) begin
            palette_ff[i] <= '0;
         end else if (hit[i]) begin
            palette_ff[i] <= color;
         end
      end

      always_comb begin
         diff_in[i].red   = abs_diff(color.red, palette_ff[i].red);
         diff_in[i].green = abs_diff(color.green, palette_ff[i].green);
         diff_in[i].blue  = abs_diff(color.blue, palette_ff[i].blue);
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            diff_ff[i] <= diff_in[i];
         end
      end

      assign diff[i] = diff_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= tag_s0;
      end
   end

   assign tag = tag_ff;

   `PNC_ASSERT_NEXT(a_load_silent, clock, reset, load_write, !tag_ff.valid, "load entered the pipeline")

endmodule

`default_nettype wire

FILE: rtl/pnc_dist.sv
// Second and third pipeline stages: squared channel differences, then their sum.
// Depends on pnc_pkg.
`default_nettype none

module pnc_dist import pnc_pkg::*; #(
   parameter int unsigned ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire pnc_rgb_type diff [ENTRIES],
   input  wire pnc_tag_type diff_tag,
   output logic [DIST_W-1:0] distance [ENTRIES],
   output pnc_tag_type      tag
);

   pnc_sq_type        sq_ff [ENTRIES];
   logic [DIST_W-1:0] dist_ff [ENTRIES];
   pnc_tag_type       sq_tag_ff;
   pnc_tag_type       dist_tag_ff;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_lane
      always_ff @(posedge clock) begin
         if (advance) begin
            sq_ff[i].red   <= SQ_W'(diff[i].red) * SQ_W'(diff[i].red);
            sq_ff[i].green <= SQ_W'(diff[i].green) * SQ_W'(diff[i].green);
            sq_ff[i].blue  <= SQ_W'(diff[i].blue) * SQ_W'(diff[i].blue);
            dist_ff[i]     <= DIST_W'(sq_ff[i].red) + DIST_W'(sq_ff[i].green)
                              + DIST_W'(sq_ff[i].blue);
         end
      end

      assign distance[i] = dist_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_tag_ff   <= '0;
         dist_tag_ff <= '0;
      end else if (advance) begin
         sq_tag_ff   <= diff_tag;
         dist_tag_ff <= sq_tag_ff;
      end
   end

   assign tag = dist_tag_ff;

endmodule

`default_nettype wire

FILE: rtl/pnc_argmin.sv
// Registered comparison tree that selects the nearest entry, one tree level per stage.
// Depends on pnc_pkg and the assertion macro header.
`default_nettype none
`include "palette_nearest_color_16_macros.svh"

module pnc_argmin import pnc_pkg::*; #(
   parameter int unsigned ENTRIES = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic [DIST_W-1:0]            distance [ENTRIES],
   input  wire pnc_tag_type                  dist_tag,
   output logic [$clog2(ENTRIES)-1:0]        win_index,
   output pnc_tag_type                       tag
);

   localparam int unsigned IDX_W  = $clog2(ENTRIES);
   localparam int unsigned LEVELS = IDX_W;
   localparam int unsigned LEAVES = 1 << LEVELS;
   localparam int unsigned NODES  = LEAVES - 1;

   logic [DIST_W-1:0] leaf_dist [LEAVES];
   logic [IDX_W-1:0]  leaf_idx [LEAVES];
   logic [DIST_W-1:0] node_dist_ff [NODES];
   logic [IDX_W-1:0]  node_idx_ff [NODES];
   pnc_tag_type       depth_tag_ff [LEVELS];

   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      assign leaf_idx[i] = IDX_W'(i);
      if (i < ENTRIES) begin : g_real
         assign leaf_dist[i] = distance[i];
      end else begin : g_pad
         assign leaf_dist[i] = DIST_PAD;
      end
   end

   for (genvar k = 0; k < NODES; k++) begin : g_node
      localparam int unsigned LEFT  = 2 * k + 1;
      localparam int unsigned RIGHT = 2 * k + 2;
      logic [DIST_W-1:0] l_dist, r_dist;
      logic [IDX_W-1:0]  l_idx, r_idx;

      if (LEFT >= NODES) begin : g_from_leaf
         assign l_dist = leaf_dist[LEFT - NODES];
         assign l_idx  = leaf_idx[LEFT - NODES];
         assign r_dist = leaf_dist[RIGHT - NODES];
         assign r_idx  = leaf_idx[RIGHT - NODES];
      end else begin : g_from_node
         assign l_dist = node_dist_ff[LEFT];
         assign l_idx  = node_idx_ff[LEFT];
         assign r_dist = node_dist_ff[RIGHT];
         assign r_idx  = node_idx_ff[RIGHT];
      end

      // The right side wins only when strictly nearer, so the lower index keeps ties.
      always_ff @(posedge clock) begin
         if (advance) begin
            if (r_dist < l_dist) begin
               node_dist_ff[k] <= r_dist;
               node_idx_ff[k]  <= r_idx;
            end else begin
               node_dist_ff[k] <= l_dist;
               node_idx_ff[k]  <= l_idx;
            end
         end
      end
   end

   for (genvar d = 0; d < LEVELS; d++) begin : g_depth
      pnc_tag_type depth_tag_in;

      if (d == LEVELS - 1) begin : g_bottom
         assign depth_tag_in = dist_tag;
      end else begin : g_upper
         assign depth_tag_in = depth_tag_ff[d + 1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            depth_tag_ff[d] <= '0;
         end else if (advance) begin
            depth_tag_ff[d] <= depth_tag_in;
         end
      end
   end

   assign win_index = node_idx_ff[0];
   assign tag       = depth_tag_ff[0];

   `PNC_ASSERT_IMPLY(a_root_dist, clock, reset, depth_tag_ff[0].valid,
      node_dist_ff[0] <= DIST_MAX, "padding lane won the search")
   `PNC_ASSERT_IMPLY(a_root_index, clock, reset, depth_tag_ff[0].valid,
      (IDX_W + 1)'(node_idx_ff[0]) < (IDX_W + 1)'(ENTRIES), "winner outside the palette")

endmodule

`default_nettype wire

FILE: rtl/palette_nearest_color_16.sv
// Nearest palette color quantizer: maps each RGB pixel to the closest palette entry.
// Usage:
//   The request channel carries load and pixel transactions. A load transaction
//   (mode 0) writes one palette entry and returns nothing; its entry is seen by
//   every pixel accepted after it. A pixel transaction (mode 1) returns one
//   response with the index of the nearest entry by squared RGB distance, the
//   lowest index winning a tie, and a copy of last_pixel as frame_end.
//   One transaction is accepted per clock while the pipeline is not held. A response
//   passes these registers in order: the channel differences, registered at the edge
//   that accepts its request, then one stage of squares, one of sums, one per
//   comparison tree level and the response register.
//   Reset clears the palette to black and empties the pipeline.
//   When the receiver holds rsp_bus.ready low with a response waiting, the whole
//   pipeline holds and req_bus.ready falls, so nothing is lost or repeated.
// Depends on pnc_pkg, the channel interfaces, pnc_diff, pnc_dist and pnc_argmin.
`default_nettype none
`include "palette_nearest_color_16_macros.svh"

module palette_nearest_color_16 import pnc_pkg::*; #(
   parameter int unsigned PALETTE_ENTRIES = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   pnc_req_if.sink   req_bus,
   pnc_rsp_if.source rsp_bus
);

   localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);

   logic        advance;
   logic        accept;
   logic        load_write;
   pnc_rgb_type color;
   pnc_tag_type tag_s0;
   pnc_rgb_type diff [PALETTE_ENTRIES];
   pnc_tag_type diff_tag;
   logic [DIST_W-1:0] distance [PALETTE_ENTRIES];
   pnc_tag_type dist_tag;
   logic [IDX_W-1:0] win_index;
   pnc_tag_type root_tag;
   logic [IDX_W+INDEX_W-1:0] win_wide;

   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] color_index_ff;
   logic               frame_end_ff;

   assign advance    = !rsp_valid_ff || rsp_bus.ready;
   assign accept     = req_bus.valid && advance;
   assign load_write = accept && (req_bus.mode == MODE_LOAD);
   assign color      = '{red: req_bus.red, green: req_bus.green, blue: req_bus.blue};
   assign tag_s0     = '{valid: accept && (req_bus.mode == MODE_PIXEL),
                         last: req_bus.last_pixel};
   assign req_bus.ready = advance;

   pnc_diff #(.ENTRIES(PALETTE_ENTRIES)) u_diff (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .load_write  (load_write),
      .entry_index (req_bus.entry_index),
      .color       (color),
      .tag_s0      (tag_s0),
      .diff        (diff),
      .tag         (diff_tag)
   );

   pnc_dist #(.ENTRIES(PALETTE_ENTRIES)) u_dist (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .diff     (diff),
      .diff_tag (diff_tag),
      .distance (distance),
      .tag      (dist_tag)
   );

   pnc_argmin #(.ENTRIES(PALETTE_ENTRIES)) u_argmin (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .distance  (distance),
      .dist_tag  (dist_tag),
      .win_index (win_index),
      .tag       (root_tag)
   );

   assign win_wide = {{INDEX_W{1'b0}}, win_index};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= root_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         color_index_ff <= win_wide[INDEX_W-1:0];
         frame_end_ff   <= root_tag.last;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.color_index = color_index_ff;
   assign rsp_bus.frame_end   = frame_end_ff;

   `PNC_ASSERT_IMPLY(a_stall_blocks, clock, reset, rsp_bus.valid && !rsp_bus.ready,
      !req_bus.ready, "request taken while response stalled")
   `PNC_ASSERT_NEXT(a_root_lands, clock, reset, root_tag.valid && advance,
      rsp_bus.valid, "tree result not registered")

endmodule

`default_nettype wire
